### src/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg: shared types, constants and tables for the month calendar grid
// Holds the queue entry type, the month tables and the reciprocal constants
// used for the divide-by-constant steps of the weekday and leap-year calculations.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int CELL_W  = 6;
  localparam int WDAY_W  = 3;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CELL_W-1:0]  LAST_CELL  = 6'd41;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

  // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] RECIP100       = 13'd5243;
  localparam int          RECIP100_SHIFT = 19;
  // floor(x / 7) = (x * 149797) >> 20, exact for x below 349525
  localparam logic [17:0] RECIP7         = 18'd149797;
  localparam int          RECIP7_SHIFT   = 20;

  typedef struct packed {
    logic              bad;
    logic [WDAY_W-1:0] fw;
    logic [DAY_W-1:0]  dim;
    logic [DAY_W-1:0]  prev_dim;
  } mcg_item_t;

  function automatic logic [WDAY_W-1:0] month_shift(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] r;
    unique case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

### src/mcg_front.sv
// ----------------------------------------------------------------------------
// mcg_front: date intake and classification
// Three-stage pipeline: validates the date, finds the month length, the
// length of the previous month and the weekday of the first of the month.
// ----------------------------------------------------------------------------
module mcg_front
  import mcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day_of_month,
  input  logic               full,
  output logic               push,
  output mcg_item_t          item
);

  logic               en1, en2, en3, accept;
  logic               v1, v2, v3;

  // stage 1
  logic [14:0]        a_in;
  logic [27:0]        pa_in;
  logic [26:0]        py_in;
  logic [YEAR_W-1:0]  y1;
  logic [MONTH_W-1:0] m1;
  logic [DAY_W-1:0]   d1;
  logic [14:0]        a1;
  logic [27:0]        pa1;
  logic [26:0]        py1;

  // stage 2
  logic [8:0]         qa;
  logic [7:0]         qy;
  logic [YEAR_W-1:0]  r100;
  logic               leap;
  logic [DAY_W-1:0]   dim_c, prev_c;
  logic               bad_c;
  logic [14:0]        s_c;
  logic [14:0]        s2;
  logic               bad2;
  logic [DAY_W-1:0]   dim2, prev2;

  // stage 3
  logic [32:0]        ps3;
  logic [14:0]        s3;
  logic               bad3;
  logic [DAY_W-1:0]   dim3, prev3;
  logic [12:0]        q7;
  logic [14:0]        rem7;

  assign en3    = !v3 || !full;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign accept = start && en1;
  assign busy   = !en1;
  assign push   = v3 && !full;

  // January and February count as months of the year before
  assign a_in  = 15'(year) + 15'd400 - 15'(month < MONTH_MAR);
  assign pa_in = 28'(a_in) * 28'(RECIP100);
  assign py_in = 27'(year) * 27'(RECIP100);

  assign qa   = pa1[27:RECIP100_SHIFT];
  assign qy   = py1[26:RECIP100_SHIFT];
  assign r100 = y1 - YEAR_W'({6'd0, qy} * 14'd100);
  assign leap = (y1[1:0] == 2'd0) && ((r100 != '0) || (qy[1:0] == 2'd0));

  always_comb begin
    dim_c  = month_days(m1, leap);
    prev_c = (m1 == MONTH_JAN) ? 5'd31 : month_days(m1 - 4'd1, leap);
    bad_c  = (m1 < MONTH_JAN) || (m1 > MONTH_DEC) || (d1 == '0) || (d1 > dim_c);
    s_c    = a1 + 15'(a1[14:2]) - 15'(qa) + 15'(qa[8:2])
             + 15'(month_shift(m1)) + 15'd1;
  end

  assign q7   = ps3[32:RECIP7_SHIFT];
  assign rem7 = s3 - 15'({2'd0, q7} * 15'd7);

  assign item.bad      = bad3;
  assign item.fw       = rem7[WDAY_W-1:0];
  assign item.dim      = dim3;
  assign item.prev_dim = prev3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y1  <= year;
      m1  <= month;
      d1  <= day_of_month;
      a1  <= a_in;
      pa1 <= pa_in;
      py1 <= py_in;
    end
    if (en2) begin
      s2    <= s_c;
      bad2  <= bad_c;
      dim2  <= dim_c;
      prev2 <= prev_c;
    end
    if (en3) begin
      ps3   <= 33'(s2) * 33'(RECIP7);
      s3    <= s2;
      bad3  <= bad2;
      dim3  <= dim2;
      prev3 <= prev2;
    end
  end

endmodule

### src/mcg_queue.sv
// ----------------------------------------------------------------------------
// mcg_queue: short queue between front and back
// Register-based circular queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mcg_queue
  import mcg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mcg_item_t item_in,
  input  logic      pop,
  output mcg_item_t item_out,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  mcg_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_MAX);
  assign empty    = (count == '0);
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item_in;
  end

endmodule

### src/mcg_back.sv
// ----------------------------------------------------------------------------
// mcg_back: grid cell generator
// Takes one classified date from the queue and walks the 42 grid cells, one
// per cycle, into registered result ports; an invalid date gives one result.
// ----------------------------------------------------------------------------
module mcg_back
  import mcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mcg_item_t         head,
  input  logic              empty,
  output logic              pop,
  output logic              result_valid,
  output logic [CELL_W-1:0] cell_index,
  output logic [DAY_W-1:0]  cell_day,
  output logic              in_month,
  output logic              bad_date,
  output logic              last
);

  mcg_item_t         cur;
  logic              act;
  logic [CELL_W-1:0] cnt;
  logic              finish;
  logic [CELL_W-1:0] nday;
  logic [DAY_W-1:0]  day_c;
  logic              own_c;

  assign finish = act && (cur.bad || (cnt == LAST_CELL));
  assign pop    = !empty && (!act || finish);

  always_comb begin
    nday = cnt - CELL_W'(cur.fw) + 6'd1;
    if (cnt < CELL_W'(cur.fw)) begin
      // trailing days of the previous month
      day_c = cur.prev_dim - DAY_W'(cur.fw) + cnt[DAY_W-1:0] + 5'd1;
      own_c = 1'b0;
    end else if (nday <= CELL_W'(cur.dim)) begin
      day_c = nday[DAY_W-1:0];
      own_c = 1'b1;
    end else begin
      day_c = DAY_W'(nday - CELL_W'(cur.dim));
      own_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= act;
      if (pop) begin
        act <= 1'b1;
      end else if (finish) begin
        act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cnt <= '0;
    end else if (act) begin
      cnt <= cnt + 1'b1;
    end
    if (cur.bad) begin
      cell_index <= '0;
      cell_day   <= '0;
      in_month   <= 1'b0;
      bad_date   <= 1'b1;
      last       <= 1'b1;
    end else begin
      cell_index <= cnt;
      cell_day   <= day_c;
      in_month   <= own_c;
      bad_date   <= 1'b0;
      last       <= (cnt == LAST_CELL);
    end
  end

endmodule

### src/month_calendar_grid_top.sv
// Month calendar grid. Pulse start with a date while busy is low; the date is
// taken at that clock edge. A valid date yields 42 results, one per cycle,
// cell_index 0 to 41 of a six-week Sunday-first grid, with last set on cell
// 41; an invalid month or day yields a single result with bad_date and last
// set. Each result is present for exactly one cycle while result_valid is
// high and cannot be held off. A date passes the front pipeline stages, the
// queue and the cell generator's result registers before its first result.
// Throughput is set by the cell generator, which emits one cell per cycle.
// Dates are taken while earlier grids are still being emitted; busy rises
// only when the classification pipeline and the queue in front of the cell
// generator are full.
// ----------------------------------------------------------------------------
// month_calendar_grid_top: month calendar grid generator
// Front pipeline classifies dates into a short queue; the back walks the grid.
// ----------------------------------------------------------------------------
module month_calendar_grid_top
  import mcg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day_of_month,
  output logic               result_valid,
  output logic [CELL_W-1:0]  cell_index,
  output logic [DAY_W-1:0]   cell_day,
  output logic               in_month,
  output logic               bad_date,
  output logic               last
);

  mcg_item_t q_in, q_out;
  logic      q_push, q_pop, q_full, q_empty;

  mcg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .full         (q_full),
    .push         (q_push),
    .item         (q_in)
  );

  mcg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  mcg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_out),
    .empty        (q_empty),
    .pop          (q_pop),
    .result_valid (result_valid),
    .cell_index   (cell_index),
    .cell_day     (cell_day),
    .in_month     (in_month),
    .bad_date     (bad_date),
    .last         (last)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the month calendar grid
// Sends dates with random gaps and back-to-back runs. Each accepted date is
// laid out as a 42-cell grid, or as one error cell, by an independent
// calculation in the scoreboard. Every emitted cell is checked field by field
// in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import mcg_pkg::*;

  localparam int RANDOM_DATES = 350;
  localparam int CALM_TAIL    = 60;
  localparam int CYCLE_LIMIT  = 200000;

  class calendar_scoreboard;
    typedef struct packed {
      logic [CELL_W-1:0] idx;
      logic [DAY_W-1:0]  day;
      logic              own;
      logic              bad;
      logic              lst;
    } grid_cell_t;

    grid_cell_t expected_cells[$];
    int errors;
    int dates_seen;
    int bad_dates;
    int cells_checked;

    static function int days_in(int y, int m);
      bit leap;
      leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      case (m)
        2:            return leap ? 29 : 28;
        4, 6, 9, 11:  return 30;
        default:      return 31;
      endcase
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    // Lay out the expected grid for one accepted date transaction
    function void note_date(int y, int m, int d);
      grid_cell_t c;
      int dim, fw, prev_len, a, next;
      int shift[12];
      shift = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      dates_seen++;
      if (m < 1 || m > 12 || d < 1 || d > days_in(y, m)) begin
        c = '{idx: '0, day: '0, own: 1'b0, bad: 1'b1, lst: 1'b1};
        expected_cells.push_back(c);
        bad_dates++;
        return;
      end
      dim = days_in(y, m);
      // shift by 400 years so the January/February step back never goes negative
      a = y + 400;
      if (m < 3) a--;
      fw = (a + a / 4 - a / 100 + a / 400 + shift[m-1] + 1) % 7;
      prev_len = (m == 1) ? 31 : days_in(y, m - 1);
      next = 1;
      for (int i = 0; i < 42; i++) begin
        c.idx = CELL_W'(i);
        c.bad = 1'b0;
        c.lst = (i == 41);
        if (i < fw) begin
          c.day = DAY_W'(prev_len - (fw - i) + 1);
          c.own = 1'b0;
        end else if (next <= dim) begin
          c.day = DAY_W'(next);
          c.own = 1'b1;
          next++;
        end else begin
          c.day = DAY_W'(next - dim);
          c.own = 1'b0;
          next++;
        end
        expected_cells.push_back(c);
      end
    endfunction

    function void compare_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_cell(logic [CELL_W-1:0] idx, logic [DAY_W-1:0] day,
                             logic own, logic bad, logic lst);
      grid_cell_t e;
      if (expected_cells.size() == 0) begin
        $error("cell with no date pending: cell_index %0d, cell_day %0d", idx, day);
        errors++;
        return;
      end
      e = expected_cells.pop_front();
      cells_checked++;
      compare_field("cell_index", e.idx, idx);
      compare_field("cell_day", CELL_W'(e.day), CELL_W'(day));
      compare_field("in_month", CELL_W'(e.own), CELL_W'(own));
      compare_field("bad_date", CELL_W'(e.bad), CELL_W'(bad));
      compare_field("last", CELL_W'(e.lst), CELL_W'(lst));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [YEAR_W-1:0]  year = '0;
  logic [MONTH_W-1:0] month = '0;
  logic [DAY_W-1:0]   day_of_month = '0;
  logic               busy;
  logic               result_valid;
  logic [CELL_W-1:0]  cell_index;
  logic [DAY_W-1:0]   cell_day;
  logic               in_month;
  logic               bad_date;
  logic               last;

  calendar_scoreboard sb;
  int cycle_count = 0;

  month_calendar_grid_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .result_valid (result_valid),
    .cell_index   (cell_index),
    .cell_day     (cell_day),
    .in_month     (in_month),
    .bad_date     (bad_date),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Note accepted dates and check emitted cells on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_date(int'(year), int'(month), int'(day_of_month));
      if (result_valid) sb.check_cell(cell_index, cell_day, in_month, bad_date, last);
    end
  end

  // Hold start high until the date transaction is taken
  task automatic send_date(input int y, input int m, input int d);
    start        <= 1'b1;
    year         <= y[YEAR_W-1:0];
    month        <= m[MONTH_W-1:0];
    day_of_month <= d[DAY_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_grid_drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic pick_date(output int y, output int m, output int d);
    int kind, dim;
    kind = $urandom_range(9);
    y = ($urandom_range(7) == 0) ? $urandom_range(16383, 0) : $urandom_range(9999, 1);
    m = $urandom_range(12, 1);
    dim = calendar_scoreboard::days_in(y, m);
    if (kind < 8) begin
      d = $urandom_range(dim, 1);
    end else if (kind == 8) begin
      // day just outside the month
      if (dim < 31 && $urandom_range(1)) d = $urandom_range(31, dim + 1);
      else d = 0;
    end else begin
      m = $urandom_range(15, 0);
      d = $urandom_range(31, 0);
    end
  endtask

  initial begin
    int y, m, d;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_date(2000, 2, 29);   // leap by the 400 rule
    send_date(1900, 2, 29);   // century, not leap
    send_date(1900, 2, 28);
    send_date(2024, 2, 29);
    send_date(2023, 2, 29);
    hold_off(3);
    send_date(1, 1, 1);       // January looks back to December
    send_date(9999, 12, 31);
    send_date(0, 1, 15);      // year zero
    send_date(0, 2, 29);
    send_date(16383, 7, 4);
    send_date(2024, 0, 10);
    send_date(2024, 13, 1);
    send_date(2024, 15, 31);
    send_date(2024, 4, 31);
    send_date(2024, 6, 0);
    hold_off(7);
    send_date(2024, 3, 1);    // after a leap February
    send_date(2023, 3, 31);
    send_date(2023, 1, 31);
    send_date(2026, 2, 1);    // month starting on a Sunday
    send_date(2025, 8, 31);   // needs all six rows
    send_date(2022, 1, 31);   // month starting on a Saturday
    send_date(2024, 11, 30);
    send_date(2024, 9, 31);
    send_date(400, 2, 29);
    send_date(16383, 15, 31);

    for (int n = 0; n < RANDOM_DATES; n++) begin
      if (n == RANDOM_DATES / 2) wait_for_grid_drain();
      else if (n < RANDOM_DATES - CALM_TAIL && $urandom_range(3) == 0)
        hold_off($urandom_range(11, 1));
      pick_date(y, m, d);
      send_date(y, m, d);
    end

    wait_for_grid_drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d dates (%0d invalid), including leap, century and year-zero cases.",
             sb.dates_seen, sb.bad_dates);
    $display("Checked %0d grid cells with random start gaps and back-to-back runs.",
             sb.cells_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
